// ----- design/psk_pkg.sv -----
// ----------------------------------------------------------------------------
// psk_pkg: shared definitions for the positional stack
// Opcodes, status codes, cell commands and default sizes.
// ----------------------------------------------------------------------------
package psk_pkg;

  // Default sizes for the top-level parameters.
  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // Width of the opcode field.
  localparam int OPC_W = 3;

  // Operation codes; the two unused codes are no-ops.
  typedef enum logic [OPC_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_DELETE = 3'd2,
    OP_INSERT = 3'd3,
    OP_READ   = 3'd4,
    OP_CLEAR  = 3'd5
  } opcode_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Command broadcast to every cell of the row.
  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2
  } cell_cmd_e;

endpackage

// ----- design/psk_cell.sv -----
// ----------------------------------------------------------------------------
// psk_cell: one storage cell of the stack row
// Holds the word at one fixed position and moves it up or down the row.
// ----------------------------------------------------------------------------
module psk_cell
  import psk_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int PW         = 7,
  parameter int POSITION   = 1
) (
  input  logic                  clk_i,
  input  cell_cmd_e             cmd_i,
  input  logic [PW-1:0]         pos_i,
  input  logic [DATA_WIDTH-1:0] word_i,
  input  logic [DATA_WIDTH-1:0] above_i,
  input  logic [DATA_WIDTH-1:0] below_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic [DATA_WIDTH-1:0] rd_o
);

  localparam logic [PW-1:0] MY_POS = PW'(POSITION);

  logic [DATA_WIDTH-1:0] data_d, data_q;

  // Next word: cells above the target hold, the target loads or takes the
  // word from below, cells under it shift.
  always_comb begin
    data_d = data_q;
    case (cmd_i)
      CMD_INSERT: begin
        if (MY_POS == pos_i) begin
          data_d = word_i;
        end else if (MY_POS > pos_i) begin
          data_d = above_i;
        end
      end
      CMD_DELETE: begin
        if (MY_POS >= pos_i) begin
          data_d = below_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  // Word storage.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

  // Read tap: only the addressed cell drives a nonzero word.
  assign rd_o = (MY_POS == pos_i) ? data_q : '0;

endmodule

// ----- design/psk_chain.sv -----
// ----------------------------------------------------------------------------
// psk_chain: row of stack cells
// Links the cells to their neighbors and combines their read taps.
// ----------------------------------------------------------------------------
module psk_chain
  import psk_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int PW         = 7
) (
  input  logic                  clk_i,
  input  cell_cmd_e             cmd_i,
  input  logic [PW-1:0]         pos_i,
  input  logic [DATA_WIDTH-1:0] word_i,
  output logic [DATA_WIDTH-1:0] rd_o
);

  logic [DATA_WIDTH-1:0] data [DEPTH];
  logic [DATA_WIDTH-1:0] rd   [DEPTH];

  // Cell k holds position k+1, so cell 0 is the top of the stack.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] above, below;

    if (k == 0) begin : g_top
      assign above = '0;
    end else begin : g_mid_a
      assign above = data[k-1];
    end

    if (k == DEPTH - 1) begin : g_bottom
      assign below = '0;
    end else begin : g_mid_b
      assign below = data[k+1];
    end

    psk_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .PW         (PW),
      .POSITION   (k + 1)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd_i),
      .pos_i   (pos_i),
      .word_i  (word_i),
      .above_i (above),
      .below_i (below),
      .data_o  (data[k]),
      .rd_o    (rd[k])
    );
  end

  // At most one tap is nonzero, so an OR of all taps selects the word.
  always_comb begin
    rd_o = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rd_o = rd_o | rd[k];
    end
  end

endmodule

// ----- design/positional_stack.sv -----
// ----------------------------------------------------------------------------
// positional_stack: LIFO stack with insert, delete and read at a position
// Stream-in operations, one result per operation, row-of-cells storage.
// ----------------------------------------------------------------------------
// Every operation acts on the row when it is accepted: the entries live in a row
// of cells that all shift up or down together, so push, pop, insert and delete
// at any position move the whole row in one step, and a read picks one cell.
// The result is held in an output register; a new operation is taken in every
// cycle in which that register is empty or its result is being taken, so the
// sustained rate is one operation per cycle. Position 1 is the top of the
// stack. An insert run places its first value at the given position and each
// later value one place below the previous one; tlast ends the run.
module positional_stack
  import psk_pkg::*;
#(
  parameter  int DEPTH      = DEPTH_DEF,
  parameter  int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int PW         = $clog2(DEPTH + 1),
  localparam int IN_W       = ((OPC_W + PW + DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_W      = ((DATA_WIDTH + 2 + PW + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // Fields from bit 0 up: opcode, position, value, zero padding.
  input  logic [IN_W-1:0]  s_axis_tdata_i,
  // Marks the last value of an insert run.
  input  logic             s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // Fields from bit 0 up: read_value, status, count, zero padding.
  output logic [OUT_W-1:0] m_axis_tdata_o
);

  localparam logic [PW:0] DEPTH_X = (PW + 1)'(DEPTH);

  // Input fields.
  opcode_e               op;
  logic [PW-1:0]         pos;
  logic [DATA_WIDTH-1:0] word;
  logic                  last;

  assign op   = opcode_e'(s_axis_tdata_i[OPC_W-1:0]);
  assign pos  = s_axis_tdata_i[OPC_W +: PW];
  assign word = s_axis_tdata_i[OPC_W + PW +: DATA_WIDTH];
  assign last = s_axis_tlast_i;

  // Control state.
  logic [PW-1:0] cnt_d, cnt_q;
  logic [PW:0]   cursor_d, cursor_q;
  logic          run_d, run_q;
  logic          out_valid_d, out_valid_q;

  // Result register.
  logic [DATA_WIDTH-1:0] rv_d, rv_q;
  status_e               st_d, st_q;
  logic [PW-1:0]         cnt_out_q;

  logic                  in_fire;
  cell_cmd_e             cmd, cmd_gated;
  logic [PW-1:0]         cpos;
  logic [DATA_WIDTH-1:0] rd;
  logic [PW:0]           cnt_ext, tgt, hi;
  logic                  empty, full;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign cnt_ext = {1'b0, cnt_q};
  assign empty   = (cnt_q == '0);
  assign full    = (cnt_ext == DEPTH_X);
  assign tgt     = run_q ? cursor_q : {1'b0, pos};
  assign hi      = run_q ? cnt_ext + 1'b1 : cnt_ext;

  // Decode the operation into a row command, a status and the new state.
  always_comb begin
    cmd      = CMD_HOLD;
    cpos     = pos;
    st_d     = ST_OK;
    rv_d     = '0;
    cnt_d    = cnt_q;
    cursor_d = cursor_q;
    run_d    = run_q;
    case (op)
      OP_PUSH: begin
        run_d = 1'b0;
        if (full) begin
          st_d = ST_FULL;
        end else begin
          cmd   = CMD_INSERT;
          cpos  = PW'(1);
          cnt_d = cnt_q + 1'b1;
        end
      end
      OP_POP: begin
        run_d = 1'b0;
        cpos  = PW'(1);
        if (empty) begin
          st_d = ST_EMPTY;
        end else begin
          cmd   = CMD_DELETE;
          rv_d  = rd;
          cnt_d = cnt_q - 1'b1;
        end
      end
      OP_DELETE, OP_READ: begin
        run_d = 1'b0;
        if (empty) begin
          st_d = ST_EMPTY;
        end else if (pos == '0 || pos > cnt_q) begin
          st_d = ST_RANGE;
        end else if (op == OP_READ) begin
          rv_d = rd;
        end else begin
          cmd   = CMD_DELETE;
          cnt_d = cnt_q - 1'b1;
        end
      end
      OP_INSERT: begin
        cpos = tgt[PW-1:0];
        if (full) begin
          st_d  = ST_FULL;
          run_d = 1'b0;
        end else if (tgt == '0 || tgt > hi) begin
          st_d  = ST_RANGE;
          run_d = 1'b0;
        end else begin
          cmd      = CMD_INSERT;
          cnt_d    = cnt_q + 1'b1;
          cursor_d = tgt + 1'b1;
          run_d    = !last;
        end
      end
      OP_CLEAR: begin
        run_d = 1'b0;
        cnt_d = '0;
      end
      default: begin
        cmd = CMD_HOLD;
      end
    endcase
  end

  // The row only moves on an accepted transfer.
  assign cmd_gated = in_fire ? cmd : CMD_HOLD;

  psk_chain #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .PW         (PW)
  ) u_chain (
    .clk_i  (clk_i),
    .cmd_i  (cmd_gated),
    .pos_i  (cpos),
    .word_i (word),
    .rd_o   (rd)
  );

  // Output valid: set by an accepted operation, cleared when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      cursor_q    <= '0;
      run_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        cnt_q    <= cnt_d;
        cursor_q <= cursor_d;
        run_q    <= run_d;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rv_q      <= rv_d;
      st_q      <= st_d;
      cnt_out_q <= cnt_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_W'({cnt_out_q, st_q, rv_q});

endmodule

// ----- design/psk_checker.sv -----
// ----------------------------------------------------------------------------
// psk_checker: port-level checks for the positional stack
// Watches the stream ports and flags results that cannot occur.
// ----------------------------------------------------------------------------
module psk_checker
  import psk_pkg::*;
#(
  parameter  int DEPTH      = DEPTH_DEF,
  parameter  int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int PW         = $clog2(DEPTH + 1),
  localparam int IN_W       = ((OPC_W + PW + DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_W      = ((DATA_WIDTH + 2 + PW + 7) / 8) * 8
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid_i,
  input logic             s_axis_tready_o,
  input logic [IN_W-1:0]  s_axis_tdata_i,
  input logic             s_axis_tlast_i,
  input logic             m_axis_tvalid_o,
  input logic             m_axis_tready_i,
  input logic [OUT_W-1:0] m_axis_tdata_o
);

  logic [DATA_WIDTH-1:0] rv;
  logic [1:0]            st;
  logic [PW-1:0]         cnt;
  logic                  clear_in;

  assign rv       = m_axis_tdata_o[DATA_WIDTH-1:0];
  assign st       = m_axis_tdata_o[DATA_WIDTH +: 2];
  assign cnt      = m_axis_tdata_o[DATA_WIDTH + 2 +: PW];
  assign clear_in = s_axis_tvalid_i && s_axis_tready_o &&
                    (s_axis_tdata_i[OPC_W-1:0] == OP_CLEAR);

  // The count never exceeds the depth.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (cnt <= PW'(DEPTH)))
    else $error("count above depth");

  // A rejected operation returns a zero word.
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && st != ST_OK) |-> (rv == '0))
    else $error("rejected operation returned a word");

  // With no result pending the input side is always ready.
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output register");

  // A clear is answered in the next cycle with an empty stack.
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_in |=> (m_axis_tvalid_o && cnt == '0 && st == ST_OK))
    else $error("clear did not empty the stack");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result changed");

endmodule

bind positional_stack psk_checker #(
  .DEPTH      (DEPTH),
  .DATA_WIDTH (DATA_WIDTH)
) u_psk_checker (.*);

// ----- tb/psk_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// psk_scoreboard: result predictor and scoreboard for the positional stack
// Watches the operation and result channels. Each accepted operation runs
// through a local copy of the stack and queues the result it should produce.
// Each accepted result is compared field by field with the oldest one queued.
// ----------------------------------------------------------------------------
module psk_scoreboard
  import psk_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        op_valid_i,
  input  logic        op_ready_i,
  // Fields from bit 0 up: opcode, position, value, zero padding.
  input  logic [47:0] op_data_i,
  input  logic        op_last_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  // Fields from bit 0 up: read_value, status, count, zero padding.
  input  logic [47:0] res_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          level_o
);

  localparam int DEPTH    = DEPTH_DEF;
  localparam int DW       = DATA_WIDTH_DEF;
  localparam int PW       = $clog2(DEPTH + 1);
  localparam int POS_LSB  = OPC_W;
  localparam int WORD_LSB = OPC_W + PW;
  localparam int STAT_LSB = DW;
  localparam int CNT_LSB  = DW + 2;
  localparam int PAD_LSB  = DW + 2 + PW;

  typedef struct packed {
    logic signed [DW-1:0] word;
    status_e              status;
    logic [PW-1:0]        count;
  } stack_result_t;

  // Local copy of the stack: index 0 is the bottom entry.
  logic signed [DW-1:0] cells [DEPTH];
  int                   level;
  int                   cursor;
  bit                   run_open;
  stack_result_t        expected_q [$];

  // Carry out one operation on the local stack and work out its result.
  task automatic apply_op(input logic [OPC_W-1:0] op, input int pos,
                          input logic signed [DW-1:0] word, input bit last,
                          output stack_result_t res);
    int target;
    int limit;
    int slot;
    res = '{word: '0, status: ST_OK, count: '0};
    // Any real operation other than insert closes an open insert run.
    if (op <= OP_CLEAR && op != OP_INSERT) run_open = 1'b0;
    case (op)
      OP_PUSH: begin
        if (level >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          cells[level] = word;
          level++;
        end
      end
      OP_POP: begin
        if (level == 0) begin
          res.status = ST_EMPTY;
        end else begin
          level--;
          res.word = cells[level];
        end
      end
      OP_DELETE, OP_READ: begin
        if (level == 0) begin
          res.status = ST_EMPTY;
        end else if (pos < 1 || pos > level) begin
          res.status = ST_RANGE;
        end else begin
          slot = level - pos;
          if (op == OP_READ) begin
            res.word = cells[slot];
          end else begin
            for (int i = slot; i + 1 < level; i++) cells[i] = cells[i + 1];
            level--;
          end
        end
      end
      OP_INSERT: begin
        // A run continues at the cursor and may also land just below the bottom.
        target = run_open ? cursor : pos;
        limit  = run_open ? level + 1 : level;
        if (level >= DEPTH) begin
          res.status = ST_FULL;
          run_open   = 1'b0;
        end else if (target < 1 || target > limit) begin
          res.status = ST_RANGE;
          run_open   = 1'b0;
        end else begin
          slot = level + 1 - target;
          for (int i = level; i > slot; i--) cells[i] = cells[i - 1];
          cells[slot] = word;
          level++;
          cursor   = target + 1;
          run_open = !last;
        end
      end
      OP_CLEAR: level = 0;
      default: ;
    endcase
    res.count = PW'(level);
  endtask

  // Compare results first, then predict the operation taken at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    stack_result_t want;
    stack_result_t got;
    if (!rst_ni) begin
      level    = 0;
      cursor   = 0;
      run_open = 1'b0;
      expected_q.delete();
      fail_count_o = 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        got.word   = res_data_i[DW-1:0];
        got.status = status_e'(res_data_i[STAT_LSB +: 2]);
        got.count  = res_data_i[CNT_LSB +: PW];
        if (expected_q.size() == 0) begin
          $error("unexpected result transfer: data %h", res_data_i);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (got.word !== want.word) begin
            $error("read_value mismatch: expected %0d, actual %0d", want.word, got.word);
            fail_count_o++;
          end
          if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
            fail_count_o++;
          end
          if (got.count !== want.count) begin
            $error("count mismatch: expected %0d, actual %0d", want.count, got.count);
            fail_count_o++;
          end
          if (res_data_i[47:PAD_LSB] !== '0) begin
            $error("padding mismatch: expected 0, actual %h", res_data_i[47:PAD_LSB]);
            fail_count_o++;
          end
        end
      end
      if (op_valid_i && op_ready_i) begin
        apply_op(op_data_i[OPC_W-1:0], int'(op_data_i[POS_LSB +: PW]),
                 op_data_i[WORD_LSB +: DW], op_last_i, want);
        expected_q.push_back(want);
      end
    end
    pending_o <= expected_q.size();
    level_o   <= level;
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression bench for the positional stack
// Drives directed and random operations with random gaps and back-pressure;
// the scoreboard predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb;
  import psk_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int PW    = $clog2(DEPTH + 1);

  // The two unused opcodes, which must leave everything as it is.
  localparam logic [OPC_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OPC_W-1:0] OP_SPARE_B = 3'd7;

  localparam int RANDOM_OPS = 450;

  logic        clk_i;
  logic        rst_ni;
  logic        s_valid;
  logic        s_ready;
  logic [47:0] s_data;
  logic        s_last;
  logic        m_valid;
  logic        m_ready;
  logic [47:0] m_data;

  int fail_count;
  int pending;
  int level;
  int sent_ops;
  bit quiet;
  bit send_calm;
  bit recv_calm;
  int stall_left;

  positional_stack dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  psk_scoreboard u_scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_valid_i   (s_valid),
    .op_ready_i   (s_ready),
    .op_data_i    (s_data),
    .op_last_i    (s_last),
    .res_valid_i  (m_valid),
    .res_ready_i  (m_ready),
    .res_data_i   (m_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .level_o      (level)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5ms;
    $display("positional_stack regression: fail");
    $finish;
  end

  // Result side: random stall bursts, with calm stretches and none at the end.
  initial begin
    m_ready <= 1'b0;
    stall_left = 0;
    recv_calm  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 99) == 0) recv_calm = !recv_calm;
      if (stall_left > 0) begin
        m_ready <= 1'b0;
        stall_left--;
      end else if (!quiet && !recv_calm && $urandom_range(0, 5) == 0) begin
        m_ready <= 1'b0;
        stall_left = $urandom_range(0, 15);
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // Offer one operation, after an optional gap, and wait for its transfer.
  task automatic send_op(input logic [OPC_W-1:0] op, input int pos,
                         input logic [31:0] word, input bit last);
    if (!quiet && !send_calm && $urandom_range(0, 4) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {6'b0, word, PW'(pos), op};
    s_last  <= last;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    sent_ops++;
  endtask

  // Hold back until every outstanding result has come out.
  task automatic drain_results();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Random word, with the extremes showing up often.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Mostly a valid position for the current fill, sometimes out of range.
  function automatic int pick_pos(input int lvl);
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return (lvl < DEPTH) ? $urandom_range(lvl + 1, DEPTH) : DEPTH;
      default: return $urandom_range(1, (lvl > 0) ? lvl : 1);
    endcase
  endfunction

  // One insert run; sometimes broken off by another operation.
  task automatic insert_run();
    int len;
    bit broken;
    len    = $urandom_range(1, 8);
    broken = ($urandom_range(0, 4) == 0);
    send_op(OP_INSERT, pick_pos(level), pick_word(), len == 1 && !broken);
    for (int i = 1; i < len; i++) begin
      if (broken && i == len - 1) begin
        send_op(3'($urandom_range(0, 7)), pick_pos(level), pick_word(), $urandom_range(0, 1));
      end else begin
        // The position field is ignored while the run is open.
        send_op(OP_INSERT, $urandom_range(0, DEPTH), pick_word(), i == len - 1);
      end
    end
  endtask

  // Stimulus and verdict.
  initial begin
    int n;
    s_valid   <= 1'b0;
    s_data    <= '0;
    s_last    <= 1'b0;
    rst_ni    = 1'b0;
    sent_ops  = 0;
    quiet     = 1'b0;
    send_calm = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: operations on an empty stack.
    send_op(OP_POP, 0, 32'h0, 1'b0);
    send_op(OP_READ, 1, 32'h0, 1'b0);
    send_op(OP_DELETE, 1, 32'h0, 1'b0);
    send_op(OP_INSERT, 1, 32'h1234_5678, 1'b1);
    send_op(OP_SPARE_A, 64, 32'hFFFF_FFFF, 1'b1);
    // Extreme words, then reads at good and bad positions.
    send_op(OP_PUSH, 0, 32'h8000_0000, 1'b0);
    send_op(OP_PUSH, 0, 32'h7FFF_FFFF, 1'b1);
    send_op(OP_PUSH, 0, 32'h0, 1'b0);
    send_op(OP_READ, 0, 32'h0, 1'b0);
    send_op(OP_READ, 4, 32'h0, 1'b0);
    send_op(OP_READ, 1, 32'h0, 1'b0);
    send_op(OP_READ, 3, 32'h0, 1'b0);
    send_op(OP_DELETE, 0, 32'h0, 1'b0);
    // An insert run of three at the top; later positions are ignored.
    send_op(OP_INSERT, 1, 32'hAAAA_0001, 1'b0);
    send_op(OP_INSERT, 64, 32'hAAAA_0002, 1'b0);
    send_op(OP_INSERT, 0, 32'hAAAA_0003, 1'b1);
    send_op(OP_READ, 2, 32'h0, 1'b0);
    // A run that spans an unused opcode, then one closed by a pop.
    send_op(OP_INSERT, 6, 32'h5555_0001, 1'b0);
    send_op(OP_SPARE_B, 0, 32'h0, 1'b0);
    send_op(OP_INSERT, 64, 32'h5555_0002, 1'b1);
    send_op(OP_INSERT, 2, 32'h6666_0001, 1'b0);
    send_op(OP_POP, 0, 32'h0, 1'b0);
    send_op(OP_INSERT, 0, 32'h6666_0002, 1'b1);
    send_op(OP_DELETE, 8, 32'h0, 1'b0);
    send_op(OP_DELETE, 1, 32'h0, 1'b0);
    send_op(OP_CLEAR, 0, 32'h0, 1'b0);
    drain_results();

    // Fill to overflow, then work at the full stack and its bottom entry.
    repeat (70) send_op(OP_PUSH, 0, pick_word(), $urandom_range(0, 1));
    send_op(OP_INSERT, 1, pick_word(), 1'b1);
    send_op(OP_READ, DEPTH, 32'h0, 1'b0);
    send_op(OP_DELETE, DEPTH, 32'h0, 1'b0);
    send_op(OP_INSERT, 1, pick_word(), 1'b0);
    send_op(OP_INSERT, 5, pick_word(), 1'b0);
    send_op(OP_INSERT, DEPTH, pick_word(), 1'b1);

    // Random episodes until enough operations have gone in.
    while (sent_ops < RANDOM_OPS) begin
      if (sent_ops > RANDOM_OPS - 60) quiet = 1'b1;
      send_calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1: begin
          n = $urandom_range(10, 70);
          repeat (n) send_op(OP_PUSH, $urandom_range(0, DEPTH), pick_word(),
                             $urandom_range(0, 1));
        end
        2: begin
          n = $urandom_range(10, 70);
          repeat (n) send_op(OP_POP, $urandom_range(0, DEPTH), pick_word(),
                             $urandom_range(0, 1));
        end
        3, 4, 5: insert_run();
        6, 7, 8: begin
          n = $urandom_range(5, 20);
          repeat (n) send_op(3'($urandom_range(0, 7)), pick_pos(level), pick_word(),
                             $urandom_range(0, 1));
        end
        default: begin
          send_op(OP_CLEAR, $urandom_range(0, DEPTH), pick_word(), $urandom_range(0, 1));
          repeat ($urandom_range(1, 6)) send_op(OP_PUSH, 0, pick_word(), 1'b0);
        end
      endcase
      if (!quiet && $urandom_range(0, 9) == 0) drain_results();
    end

    // Let the last results out, then give the verdict.
    drain_results();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("positional_stack regression: pass");
    end else begin
      $display("positional_stack regression: fail");
    end
    $finish;
  end

endmodule

// ----- positional_stack.f -----
design/psk_pkg.sv
design/psk_cell.sv
design/psk_chain.sv
design/positional_stack.sv
design/psk_checker.sv
tb/psk_checker.sv
tb/tb.sv
